// File: hdl/i2c_master_transfer_sequencer_assert.svh
// ----------------------------------------------------------------------------
// I2C master transfer sequencer - assertion macros
// Shorthand for concurrent checks clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_ASSERT_SVH

// check that is masked while arst_n is low
`define I2CMS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that holds at every edge, reset included
`define I2CMS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer - package
// Request kinds, bus status codes and the request and result beat layouts.
// ----------------------------------------------------------------------------
package i2cms_pkg;

	// request kinds
	typedef enum logic [1:0] {
		REQ_LOAD   = 2'd0,
		REQ_START  = 2'd1,
		REQ_STATUS = 2'd2,
		REQ_READ   = 2'd3
	} req_kind_t;

	// master status codes reported by the bus engine
	localparam logic [7:0] ST_START        = 8'h08;
	localparam logic [7:0] ST_RESTART      = 8'h10;
	localparam logic [7:0] ST_SLA_W_ACK    = 8'h18;
	localparam logic [7:0] ST_SLA_W_NACK   = 8'h20;
	localparam logic [7:0] ST_DATA_TX_ACK  = 8'h28;
	localparam logic [7:0] ST_DATA_TX_NACK = 8'h30;
	localparam logic [7:0] ST_ARB_LOST     = 8'h38;
	localparam logic [7:0] ST_SLA_R_ACK    = 8'h40;
	localparam logic [7:0] ST_SLA_R_NACK   = 8'h48;
	localparam logic [7:0] ST_DATA_RX_ACK  = 8'h50;
	localparam logic [7:0] ST_DATA_RX_NACK = 8'h58;

	// request beat
	typedef struct packed {
		req_kind_t   req_type;
		logic [4:0]  buffer_index;
		logic [7:0]  load_byte;
		logic [7:0]  start_address;
		logic [5:0]  transfer_length;
		logic [7:0]  bus_status;
		logic [7:0]  rx_byte;
	} req_t;

	// result beat
	typedef struct packed {
		logic        data_write;
		logic [7:0]  tx_value;
		logic        start_set;
		logic        start_clear;
		logic        stop_set;
		logic        ack_set;
		logic        ack_clear;
		logic        done_res;
		logic        ok;
		logic [7:0]  read_value;
	} rsp_t;

endpackage

// File: hdl/i2cms_stream_if.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer - stream interface
// Valid/ready channel carrying one beat of a given payload type.
// ----------------------------------------------------------------------------
interface i2cms_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/i2c_master_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer - top level
// Turns bus-engine status beats into engine control actions and keeps the
// transfer byte buffer.
// ----------------------------------------------------------------------------
// The block takes one request beat per clock unless the output is stalled, and
// returns exactly one result beat for each, through stage 1 and the output register.
// All per-transfer state (index, address, length, done and ok) is updated at
// the accept edge; the transfer buffer is a single-port synchronous memory
// that is read or written at that same edge, and its registered read data is
// merged into the result in the next stage, then held in an output register.
// With the output stalled, one more request is still taken into the first
// stage. Buffer entries come up undefined: read only what was loaded or
// received since reset. There is no clearing pass after reset.
module i2c_master_transfer_sequencer #(
	parameter int BUFFER_DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	i2cms_stream_if.sink      request,
	i2cms_stream_if.source    result
);
	import i2cms_pkg::*;
	`include "i2c_master_transfer_sequencer_assert.svh"

	localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
	localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CMP_W  = (CNT_W > 6) ? CNT_W : 6;
	localparam logic [CNT_W-1:0] DEPTH_N = CNT_W'(BUFFER_DEPTH);
	localparam logic [CMP_W-1:0] DEPTH_W = CMP_W'(BUFFER_DEPTH);

	// first-stage bundle: actions plus how to finish the byte fields
	typedef struct packed {
		logic        data_write;
		logic [7:0]  tx_const;
		logic        tx_from_mem;
		logic        rd_from_mem;
		logic        start_set;
		logic        start_clear;
		logic        stop_set;
		logic        ack_set;
		logic        ack_clear;
		logic        done_res;
		logic        ok;
	} stage_t;

	req_t             req;
	logic             accept;
	logic             adv_s1;

	// transfer state
	logic [CNT_W-1:0] byte_index_q, byte_index_n;
	logic [7:0]       slave_address_q, slave_address_n;
	logic [CNT_W-1:0] length_limit_q, length_limit_n;
	logic             done_flag_q, done_flag_n;
	logic             ok_flag_q, ok_flag_n;

	// buffer memory
	logic [7:0]       mem [BUFFER_DEPTH];
	logic             mem_we, mem_re;
	logic [ADDR_W-1:0] mem_addr;
	logic [7:0]       mem_wdata;
	logic [7:0]       rdata_s1;

	// pipeline
	stage_t           stage_n, stage_s1;
	logic             valid_s1_q;
	rsp_t             rsp_n, rsp_s2;
	logic             valid_s2_q;

	// helpers
	logic             bidx_ok;
	logic             idx_ok;
	logic [CNT_W-1:0] idx_inc;
	logic [ADDR_W-1:0] bidx_addr;
	logic [ADDR_W-1:0] idx_addr;
	logic [CMP_W-1:0] len_w;

	assign req    = request.data;
	assign adv_s1 = !valid_s2_q || result.ready;
	assign request.ready = !valid_s1_q || adv_s1;
	assign accept = request.valid && request.ready;

	assign bidx_ok   = CMP_W'(req.buffer_index) < DEPTH_W;
	assign bidx_addr = ADDR_W'(CMP_W'(req.buffer_index));
	assign idx_ok    = byte_index_q < DEPTH_N;
	assign idx_inc   = byte_index_q + CNT_W'(1);
	assign idx_addr  = byte_index_q[ADDR_W-1:0];
	assign len_w     = CMP_W'(req.transfer_length);

	// next transfer state, actions and buffer access for the offered beat
	always_comb begin
		byte_index_n    = byte_index_q;
		slave_address_n = slave_address_q;
		length_limit_n  = length_limit_q;
		done_flag_n     = done_flag_q;
		ok_flag_n       = ok_flag_q;
		stage_n         = '0;
		mem_we          = 1'b0;
		mem_re          = 1'b0;
		mem_addr        = bidx_addr;
		mem_wdata       = req.load_byte;
		case (req.req_type)
			REQ_LOAD: begin
				mem_we = bidx_ok;
			end
			REQ_START: begin
				slave_address_n   = req.start_address;
				length_limit_n    = (len_w > DEPTH_W) ? DEPTH_N : CNT_W'(len_w);
				byte_index_n      = '0;
				done_flag_n       = 1'b0;
				ok_flag_n         = 1'b0;
				stage_n.start_set = 1'b1;
			end
			REQ_READ: begin
				mem_re              = bidx_ok;
				stage_n.rd_from_mem = bidx_ok;
			end
			REQ_STATUS: begin
				mem_addr  = idx_addr;
				mem_wdata = req.rx_byte;
				case (req.bus_status)
					ST_START: begin
						stage_n.data_write  = 1'b1;
						stage_n.tx_const    = slave_address_q;
						stage_n.start_clear = 1'b1;
						if (byte_index_q >= length_limit_q) begin
							stage_n.stop_set = 1'b1;
							done_flag_n      = 1'b1;
						end
					end
					ST_RESTART: begin
						byte_index_n        = '0;
						stage_n.data_write  = 1'b1;
						stage_n.tx_const    = slave_address_q;
						stage_n.start_clear = 1'b1;
					end
					ST_SLA_W_ACK: begin
						stage_n.data_write  = 1'b1;
						mem_re              = idx_ok;
						stage_n.tx_from_mem = idx_ok;
						if (idx_ok)
							byte_index_n = idx_inc;
					end
					ST_DATA_TX_ACK: begin
						if (byte_index_q >= length_limit_q) begin
							stage_n.stop_set = 1'b1;
							done_flag_n      = 1'b1;
							ok_flag_n        = 1'b1;
						end else begin
							stage_n.data_write  = 1'b1;
							mem_re              = idx_ok;
							stage_n.tx_from_mem = idx_ok;
							if (idx_ok)
								byte_index_n = idx_inc;
						end
					end
					ST_ARB_LOST: begin
						stage_n.start_set = 1'b1;
					end
					ST_SLA_R_ACK: begin
						stage_n.ack_set = 1'b1;
					end
					ST_DATA_RX_ACK: begin
						mem_we = idx_ok;
						if (idx_ok)
							byte_index_n = idx_inc;
						if (byte_index_n >= length_limit_q)
							stage_n.ack_clear = 1'b1;
						else
							stage_n.ack_set = 1'b1;
					end
					ST_DATA_RX_NACK: begin
						stage_n.stop_set = 1'b1;
						done_flag_n      = 1'b1;
						ok_flag_n        = 1'b1;
					end
					ST_SLA_W_NACK, ST_DATA_TX_NACK, ST_SLA_R_NACK: begin
						stage_n.stop_set = 1'b1;
						done_flag_n      = 1'b1;
					end
					default: begin
						// unknown code ends the transfer, ok untouched
						stage_n.stop_set = 1'b1;
						done_flag_n      = 1'b1;
					end
				endcase
			end
			default: begin
			end
		endcase
		stage_n.done_res = done_flag_n;
		stage_n.ok       = ok_flag_n;
	end

	// transfer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q    <= '0;
			slave_address_q <= '0;
			length_limit_q  <= '0;
			done_flag_q     <= 1'b0;
			ok_flag_q       <= 1'b0;
		end else if (accept) begin
			byte_index_q    <= byte_index_n;
			slave_address_q <= slave_address_n;
			length_limit_q  <= length_limit_n;
			done_flag_q     <= done_flag_n;
			ok_flag_q       <= ok_flag_n;
		end
	end

	// buffer memory, accessed at the accept edge
	always_ff @(posedge clk) begin
		if (accept && mem_we)
			mem[mem_addr] <= mem_wdata;
		if (accept && mem_re)
			rdata_s1 <= mem[mem_addr];
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1_q <= 1'b0;
		else if (accept)
			valid_s1_q <= 1'b1;
		else if (adv_s1)
			valid_s1_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept)
			stage_s1 <= stage_n;
	end

	// merge registered buffer data into the result
	always_comb begin
		rsp_n.data_write  = stage_s1.data_write;
		rsp_n.tx_value    = stage_s1.tx_from_mem ? rdata_s1 : stage_s1.tx_const;
		rsp_n.start_set   = stage_s1.start_set;
		rsp_n.start_clear = stage_s1.start_clear;
		rsp_n.stop_set    = stage_s1.stop_set;
		rsp_n.ack_set     = stage_s1.ack_set;
		rsp_n.ack_clear   = stage_s1.ack_clear;
		rsp_n.done_res    = stage_s1.done_res;
		rsp_n.ok          = stage_s1.ok;
		rsp_n.read_value  = stage_s1.rd_from_mem ? rdata_s1 : 8'h00;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2_q <= 1'b0;
		else if (adv_s1)
			valid_s2_q <= valid_s1_q;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1_q)
			rsp_s2 <= rsp_n;
	end

	assign result.valid = valid_s2_q;
	assign result.data  = rsp_s2;

	// checks
	`I2CMS_ASSERT_ALWAYS(a_index_bound, byte_index_q <= DEPTH_N, "byte index beyond buffer")
	`I2CMS_ASSERT_ALWAYS(a_ok_needs_done, ok_flag_q |-> done_flag_q, "ok set without done")
	`I2CMS_ASSERT(a_start_clears, (accept && req.req_type == REQ_START) |=> (byte_index_q == '0 && !done_flag_q && !ok_flag_q), "start beat did not clear transfer state")
	`I2CMS_ASSERT(a_s1_moves, (valid_s1_q && adv_s1) |=> valid_s2_q, "stage 1 beat lost on advance")

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master transfer sequencer - testbench
// Sends a short table of directed request beats and then random write, read
// and noise sequences through the sequencer. Every result beat is compared
// field by field with a table entry or a behavioral copy of the status state
// machine and its buffer. Sender and receiver idle at random in three mixes, with long stalls.
// ----------------------------------------------------------------------------
module testbench;
	import i2cms_pkg::*;

	localparam int DEPTH       = 32;
	localparam int ITEM_TARGET = 1100;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 60;
	localparam int MAX_REPORTS = 10;
	localparam int SETTLE      = 10;

	// status codes outside the known set, used at the two extremes
	localparam logic [7:0] UNKNOWN_HI = 8'hFF;
	localparam logic [7:0] UNKNOWN_LO = 8'h00;

	logic clk;
	logic arst_n;

	i2cms_stream_if #(.data_t(req_t)) req_if ();
	i2cms_stream_if #(.data_t(rsp_t)) rsp_if ();

	i2c_master_transfer_sequencer #(
		.BUFFER_DEPTH(DEPTH)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.request(req_if),
		.result (rsp_if)
	);

	// shadow of the sequencer state
	logic [7:0] shadow_mem [DEPTH];
	bit         shadow_loaded [DEPTH];
	int         pos;
	logic [7:0] sla_byte;
	int         limit;
	bit         done_q;
	bit         ok_q;

	rsp_t expected_actions [$];

	int errors;
	int reports;
	int beats_sent;
	int beats_checked;
	int write_xfers;
	int read_xfers;
	int tx_idle_pct;
	int rx_idle_pct;
	int hold_ticket;
	int cycles;

	typedef struct {
		req_t req;
		bit   typed;
		rsp_t want;
	} dir_row_t;

	dir_row_t dir_rows [$];

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] known_code(int k);
		case (k)
			0:       return ST_START;
			1:       return ST_RESTART;
			2:       return ST_SLA_W_ACK;
			3:       return ST_SLA_W_NACK;
			4:       return ST_DATA_TX_ACK;
			5:       return ST_DATA_TX_NACK;
			6:       return ST_ARB_LOST;
			7:       return ST_SLA_R_ACK;
			8:       return ST_SLA_R_NACK;
			9:       return ST_DATA_RX_ACK;
			default: return ST_DATA_RX_NACK;
		endcase
	endfunction

	// mostly known codes, the rest anything at all
	function automatic logic [7:0] status_pick();
		if ($urandom_range(0, 9) < 6)
			return known_code($urandom_range(0, 10));
		return rand_byte();
	endfunction

	// small lengths mostly, a few full and oversized ones
	function automatic int pick_len();
		int k;
		k = $urandom_range(0, 15);
		if (k == 0)
			return $urandom_range(33, 63);
		if (k == 1)
			return DEPTH;
		if (k < 4)
			return $urandom_range(9, 31);
		return $urandom_range(0, 8);
	endfunction

	function automatic req_t random_req();
		req_t r;
		r.req_type        = req_kind_t'($urandom_range(0, 3));
		r.buffer_index    = 5'($urandom_range(0, 31));
		r.load_byte       = rand_byte();
		r.start_address   = rand_byte();
		r.transfer_length = 6'($urandom_range(0, 63));
		r.bus_status      = status_pick();
		r.rx_byte         = rand_byte();
		return r;
	endfunction

	function automatic req_t mk_load(int idx, logic [7:0] b);
		req_t r;
		r = random_req();
		r.req_type     = REQ_LOAD;
		r.buffer_index = 5'(idx);
		r.load_byte    = b;
		return r;
	endfunction

	function automatic req_t mk_start(logic [7:0] a, logic [5:0] len);
		req_t r;
		r = random_req();
		r.req_type        = REQ_START;
		r.start_address   = a;
		r.transfer_length = len;
		return r;
	endfunction

	function automatic req_t mk_status(logic [7:0] code, logic [7:0] rx);
		req_t r;
		r = random_req();
		r.req_type   = REQ_STATUS;
		r.bus_status = code;
		r.rx_byte    = rx;
		return r;
	endfunction

	function automatic req_t mk_read(int idx);
		req_t r;
		r = random_req();
		r.req_type     = REQ_READ;
		r.buffer_index = 5'(idx);
		return r;
	endfunction

	function automatic rsp_t mk_rsp(bit dw, logic [7:0] tx, bit ss, bit sc, bit sp,
			bit aks, bit akc, bit dn, bit okv, logic [7:0] rd);
		return rsp_t'({dw, tx, ss, sc, sp, aks, akc, dn, okv, rd});
	endfunction

	task automatic add_row(input req_t r, input bit typed, input rsp_t want);
		dir_row_t row;
		row.req   = r;
		row.typed = typed;
		row.want  = want;
		dir_rows.push_back(row);
	endtask

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------
	task automatic fetch_byte(output logic [7:0] v);
		v = 8'h00;
		if (pos < DEPTH) begin
			v = shadow_mem[pos];
			pos++;
		end
	endtask

	task automatic sequencer_predict(input req_t r, output rsp_t o);
		o = '0;
		case (r.req_type)
			REQ_LOAD: begin
				shadow_mem[r.buffer_index]    = r.load_byte;
				shadow_loaded[r.buffer_index] = 1'b1;
			end
			REQ_START: begin
				sla_byte  = r.start_address;
				limit     = (r.transfer_length > DEPTH) ? DEPTH : int'(r.transfer_length);
				pos       = 0;
				done_q    = 1'b0;
				ok_q      = 1'b0;
				o.start_set = 1'b1;
			end
			REQ_READ: begin
				o.read_value = shadow_mem[r.buffer_index];
			end
			REQ_STATUS: begin
				case (r.bus_status)
					ST_START: begin
						o.data_write  = 1'b1;
						o.tx_value    = sla_byte;
						o.start_clear = 1'b1;
						if (pos >= limit) begin
							o.stop_set = 1'b1;
							done_q     = 1'b1;
						end
					end
					ST_RESTART: begin
						pos           = 0;
						o.data_write  = 1'b1;
						o.tx_value    = sla_byte;
						o.start_clear = 1'b1;
					end
					ST_SLA_W_ACK: begin
						o.data_write = 1'b1;
						fetch_byte(o.tx_value);
					end
					ST_DATA_TX_ACK: begin
						if (pos >= limit) begin
							o.stop_set = 1'b1;
							done_q     = 1'b1;
							ok_q       = 1'b1;
						end else begin
							o.data_write = 1'b1;
							fetch_byte(o.tx_value);
						end
					end
					ST_ARB_LOST: o.start_set = 1'b1;
					ST_SLA_R_ACK: o.ack_set = 1'b1;
					ST_DATA_RX_ACK: begin
						// bytes past the buffer end are dropped
						if (pos < DEPTH) begin
							shadow_mem[pos]    = r.rx_byte;
							shadow_loaded[pos] = 1'b1;
							pos++;
						end
						if (pos >= limit)
							o.ack_clear = 1'b1;
						else
							o.ack_set = 1'b1;
					end
					ST_DATA_RX_NACK: begin
						o.stop_set = 1'b1;
						done_q     = 1'b1;
						ok_q       = 1'b1;
					end
					// both NACK cases, lost read address and unknown codes
					default: begin
						o.stop_set = 1'b1;
						done_q     = 1'b1;
					end
				endcase
			end
			default: begin
			end
		endcase
		o.done_res = done_q;
		o.ok       = ok_q;
	endtask

	// would this beat read a buffer entry that holds nothing yet
	function automatic bit reads_unwritten(req_t r);
		if (r.req_type == REQ_READ)
			return !shadow_loaded[r.buffer_index];
		if (r.req_type == REQ_STATUS && pos < DEPTH) begin
			if (!shadow_loaded[pos]) begin
				if (r.bus_status == ST_SLA_W_ACK)
					return 1'b1;
				if (r.bus_status == ST_DATA_TX_ACK && pos < limit)
					return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// ------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------
	task automatic offer(input req_t r, input bit typed, input rsp_t want);
		rsp_t predicted;
		// fill the entry first instead of reading garbage
		if (reads_unwritten(r)) begin
			if (r.req_type == REQ_STATUS)
				r.buffer_index = 5'(pos);
			r.req_type = REQ_LOAD;
		end
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= r;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		sequencer_predict(r, predicted);
		expected_actions.push_back(typed ? want : predicted);
		beats_sent++;
	endtask

	// sender pause until every result is back
	task automatic drain_results();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (expected_actions.size() != 0);
	endtask

	task automatic flag_failure(input string msg);
		errors++;
		if (reports < MAX_REPORTS)
			$display("%s", msg);
		reports++;
	endtask

	// main sequence
	initial begin
		rsp_t       none;
		logic [7:0] a;
		int         len;
		int         eff;
		int         n;
		int         k;
		int         phase;

		none = '0;
		arst_n       <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.data  <= '0;
		tx_idle_pct = 32;
		rx_idle_pct = 70;

		// directed table: status before any start, unknown codes at both ends
		add_row(mk_status(ST_START, rand_byte()), 1'b1,
			mk_rsp(1, 8'h00, 0, 1, 1, 0, 0, 1, 0, 8'h00));
		add_row(mk_status(UNKNOWN_HI, rand_byte()), 1'b1,
			mk_rsp(0, 8'h00, 0, 0, 1, 0, 0, 1, 0, 8'h00));
		add_row(mk_status(UNKNOWN_LO, rand_byte()), 1'b1,
			mk_rsp(0, 8'h00, 0, 0, 1, 0, 0, 1, 0, 8'h00));
		add_row(mk_load(0, 8'hFF), 1'b1,
			mk_rsp(0, 8'h00, 0, 0, 0, 0, 0, 1, 0, 8'h00));
		add_row(mk_load(1, 8'hA5), 1'b0, none);
		add_row(mk_load(31, 8'h00), 1'b0, none);
		add_row(mk_read(0), 1'b1,
			mk_rsp(0, 8'h00, 0, 0, 0, 0, 0, 1, 0, 8'hFF));
		// two byte write transfer
		add_row(mk_start(8'hA4, 6'd2), 1'b1,
			mk_rsp(0, 8'h00, 1, 0, 0, 0, 0, 0, 0, 8'h00));
		add_row(mk_status(ST_START, rand_byte()), 1'b0, none);
		add_row(mk_status(ST_SLA_W_ACK, rand_byte()), 1'b0, none);
		add_row(mk_status(ST_DATA_TX_ACK, rand_byte()), 1'b0, none);
		add_row(mk_status(ST_DATA_TX_ACK, rand_byte()), 1'b0, none);
		// oversized read length saturates, restart, rx bytes, then every ending
		add_row(mk_start(8'hFF, 6'd63), 1'b1,
			mk_rsp(0, 8'h00, 1, 0, 0, 0, 0, 0, 0, 8'h00));
		add_row(mk_status(ST_RESTART, rand_byte()), 1'b0, none);
		add_row(mk_status(ST_SLA_R_ACK, rand_byte()), 1'b0, none);
		add_row(mk_status(ST_DATA_RX_ACK, 8'h00), 1'b0, none);
		add_row(mk_status(ST_DATA_RX_ACK, 8'hFF), 1'b0, none);
		add_row(mk_status(ST_SLA_R_NACK, rand_byte()), 1'b0, none);
		add_row(mk_status(ST_ARB_LOST, rand_byte()), 1'b0, none);
		add_row(mk_status(ST_SLA_W_NACK, rand_byte()), 1'b0, none);
		add_row(mk_status(ST_DATA_TX_NACK, rand_byte()), 1'b0, none);
		add_row(mk_status(ST_DATA_RX_NACK, rand_byte()), 1'b0, none);
		add_row(mk_read(1), 1'b0, none);
		// zero length: the first byte already ends the transfer with NACK
		add_row(mk_start(8'h01, 6'd0), 1'b0, none);
		add_row(mk_status(ST_DATA_RX_ACK, 8'h3C), 1'b0, none);
		add_row(mk_read(31), 1'b0, none);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			offer(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

		phase = 0;
		while (beats_sent < ITEM_TARGET) begin
			// idle mix changes, with the pipe emptied at each change
			if (phase == 0 && beats_sent >= ITEM_TARGET / 3) begin
				phase = 1;
				drain_results();
				tx_idle_pct = 70;
				rx_idle_pct = 32;
			end else if (phase == 1 && beats_sent >= 2 * ITEM_TARGET / 3) begin
				phase = 2;
				drain_results();
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end

			// long receiver stall while requests keep coming
			if ((phase == 0 && hold_ticket == 0 && beats_sent >= 150) ||
					(phase == 2 && hold_ticket == 1 && beats_sent >= 900))
				hold_ticket++;

			k = $urandom_range(0, 9);
			if (k < 4) begin
				// write transfer: load, start, address, data beats
				len = pick_len();
				eff = (len > DEPTH) ? DEPTH : len;
				for (int i = 0; i < eff; i++)
					offer(mk_load(i, rand_byte()), 1'b0, none);
				a = rand_byte();
				a[0] = 1'b0;
				offer(mk_start(a, 6'(len)), 1'b0, none);
				offer(mk_status(ST_START, rand_byte()), 1'b0, none);
				if ($urandom_range(0, 9) == 0) begin
					offer(mk_status(ST_SLA_W_NACK, rand_byte()), 1'b0, none);
				end else begin
					offer(mk_status(ST_SLA_W_ACK, rand_byte()), 1'b0, none);
					n = (eff == 0) ? 1 : eff;
					for (int i = 0; i < n; i++) begin
						if ($urandom_range(0, 19) == 0) begin
							offer(mk_status(ST_DATA_TX_NACK, rand_byte()), 1'b0, none);
							break;
						end
						offer(mk_status(ST_DATA_TX_ACK, rand_byte()), 1'b0, none);
					end
				end
				// stray events after the end
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(1, 3))
						offer(mk_status(status_pick(), rand_byte()), 1'b0, none);
				write_xfers++;
			end else if (k < 8) begin
				// read transfer: start, address, rx bytes, then read back
				len = pick_len();
				eff = (len > DEPTH) ? DEPTH : len;
				a = rand_byte();
				a[0] = 1'b1;
				offer(mk_start(a, 6'(len)), 1'b0, none);
				offer(mk_status(ST_START, rand_byte()), 1'b0, none);
				if ($urandom_range(0, 9) == 0) begin
					offer(mk_status(ST_SLA_R_NACK, rand_byte()), 1'b0, none);
				end else begin
					offer(mk_status(ST_SLA_R_ACK, rand_byte()), 1'b0, none);
					n = eff;
					if ($urandom_range(0, 5) == 0)
						n += $urandom_range(1, 3);
					repeat (n)
						offer(mk_status(ST_DATA_RX_ACK, rand_byte()), 1'b0, none);
					offer(mk_status(ST_DATA_RX_NACK, rand_byte()), 1'b0, none);
					// overrun: a send here may sit at the buffer end
					if (n > eff && $urandom_range(0, 1) == 1)
						offer(mk_status(ST_SLA_W_ACK, rand_byte()), 1'b0, none);
					for (int i = 0; i < eff; i++)
						if ($urandom_range(0, 1) == 1)
							offer(mk_read(i), 1'b0, none);
				end
				read_xfers++;
			end else begin
				// noise
				repeat ($urandom_range(1, 4))
					offer(random_req(), 1'b0, none);
			end
		end

		drain_results();
		repeat (SETTLE) @(posedge clk);

		$display("Sent %0d request beats: %0d write and %0d read transfers plus noise.",
			beats_sent, write_xfers, read_xfers);
		$display("Checked %0d result beats over three idle mixes and two long stalls; %0d failed.",
			beats_checked, errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------
	// receiver: random back-pressure plus requested long holds
	initial begin
		int hold_served;
		int hold_left;
		hold_served = 0;
		hold_left   = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_ticket) begin
				hold_served = hold_ticket;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// compare each result beat with the oldest expectation
	initial begin
		rsp_t  got;
		rsp_t  want;
		string diffs;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
				got = rsp_if.data;
				if (expected_actions.size() == 0) begin
					flag_failure($sformatf("result beat %h with nothing expected", got));
				end else begin
					want = expected_actions.pop_front();
					beats_checked++;
					diffs = "";
					if (got.data_write !== want.data_write)
						diffs = {diffs, $sformatf(" data_write %b/%b", want.data_write, got.data_write)};
					if (got.tx_value !== want.tx_value)
						diffs = {diffs, $sformatf(" tx_value %h/%h", want.tx_value, got.tx_value)};
					if (got.start_set !== want.start_set)
						diffs = {diffs, $sformatf(" start_set %b/%b", want.start_set, got.start_set)};
					if (got.start_clear !== want.start_clear)
						diffs = {diffs, $sformatf(" start_clear %b/%b", want.start_clear,
							got.start_clear)};
					if (got.stop_set !== want.stop_set)
						diffs = {diffs, $sformatf(" stop_set %b/%b", want.stop_set, got.stop_set)};
					if (got.ack_set !== want.ack_set)
						diffs = {diffs, $sformatf(" ack_set %b/%b", want.ack_set, got.ack_set)};
					if (got.ack_clear !== want.ack_clear)
						diffs = {diffs, $sformatf(" ack_clear %b/%b", want.ack_clear, got.ack_clear)};
					if (got.done_res !== want.done_res)
						diffs = {diffs, $sformatf(" done_res %b/%b", want.done_res, got.done_res)};
					if (got.ok !== want.ok)
						diffs = {diffs, $sformatf(" ok %b/%b", want.ok, got.ok)};
					if (got.read_value !== want.read_value)
						diffs = {diffs, $sformatf(" read_value %h/%h", want.read_value,
							got.read_value)};
					if (diffs != "")
						flag_failure($sformatf("result %0d mismatch (expected/actual):%s",
							beats_checked, diffs));
				end
			end
		end
	end

	// run limit
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Run stopped after %0d cycles with %0d results outstanding.",
			cycles, expected_actions.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: i2c_master_transfer_sequencer.f
+incdir+hdl
hdl/i2cms_pkg.sv
hdl/i2cms_stream_if.sv
hdl/i2c_master_transfer_sequencer.sv
sim/testbench.sv
